### src/ssvs_pkg.sv
// Shared types, constants and lookup functions for the seven-segment tube scanner.
// No dependencies; used by ssvs_ctrl, ssvs_datapath and seven_segment_vfd_scanner.
`default_nettype none

package ssvs_pkg;

    // Default geometry
    localparam int DEF_NUM_DIGITS = 9;
    localparam int DEF_FRAME_BITS = 20;

    // Field widths fixed by the interface
    localparam int PERIOD_W = 8;
    localparam int CODE_W   = 4;
    localparam int INDEX_W  = 4;
    localparam int CHAR_W   = 8;
    localparam int SEG_W    = 7;
    localparam int WORD_W   = 32;

    // Reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd32;
    localparam logic [PERIOD_W-1:0] CD_RESET     = 8'd1;
    localparam logic [CODE_W-1:0]   BLANK_CODE   = 4'd15;
    localparam logic [CODE_W-1:0]   MAX_NUMERAL  = 4'd9;

    // Item kinds carried on the input tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CHAR = 1'b1;

    // Characters with a meaning
    localparam logic [CHAR_W-1:0] CHAR_CLEAR = 8'h72;  // 'r'
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;  // ' '
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'

    // Segment bit positions on the driver word
    localparam logic [SEG_W-1:0] SEG_A = 7'h01;
    localparam logic [SEG_W-1:0] SEG_F = 7'h02;
    localparam logic [SEG_W-1:0] SEG_B = 7'h04;
    localparam logic [SEG_W-1:0] SEG_G = 7'h08;
    localparam logic [SEG_W-1:0] SEG_E = 7'h10;
    localparam logic [SEG_W-1:0] SEG_C = 7'h20;
    localparam logic [SEG_W-1:0] SEG_D = 7'h40;

    // Controller -> datapath commands
    typedef struct packed {
        logic char_we;    // apply an accepted character
        logic tick;       // count down the refresh divider
        logic scan_step;  // load the frame of the current digit
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic cd_one;     // divider expires on this tick
        logic idx_last;   // scan pointer at the final digit
        logic out_free;   // output register can take a frame
    } t_stat;

    // Segment pattern of a code; blank above nine
    function automatic logic [SEG_W-1:0] seg_bits(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] s;
        case (code)
            4'd0:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    s = SEG_B | SEG_C;
            4'd2:    s = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    s = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5:    s = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6:    s = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7:    s = SEG_A | SEG_B | SEG_C;
            4'd8:    s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    s = SEG_A | SEG_B | SEG_C | SEG_F | SEG_G;
            default: s = '0;
        endcase
        return s;
    endfunction

    // Grid bit of a digit position; positions past the tube have none
    function automatic logic [WORD_W-1:0] grid_bit(input logic [INDEX_W-1:0] idx);
        logic [WORD_W-1:0] g;
        case (idx)
            4'd0:    g = 32'h0001_0000;
            4'd1:    g = 32'h0000_1000;
            4'd2:    g = 32'h0000_0800;
            4'd3:    g = 32'h0000_0400;
            4'd4:    g = 32'h0000_2000;
            4'd5:    g = 32'h0000_0200;
            4'd6:    g = 32'h0000_4000;
            4'd7:    g = 32'h0000_0080;
            4'd8:    g = 32'h0000_8000;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

### src/ssvs_ctrl.sv
// Scan controller: input handshake and the idle/scan state machine.
// Depends on ssvs_pkg for the command and status structs and item kinds.
`default_nettype none

module ssvs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_func,
    output logic                o_in_ready,
    input  wire ssvs_pkg::t_stat i_stat,
    output ssvs_pkg::t_cmd      o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    // Items are taken only between scans
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Commands
    always_comb begin
        o_cmd.char_we   = w_accept && (i_in_func == ssvs_pkg::FUNC_CHAR);
        o_cmd.tick      = w_accept && (i_in_func == ssvs_pkg::FUNC_TICK);
        o_cmd.scan_step = (r_state == ST_SCAN) && i_stat.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.tick && i_stat.cd_one) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.out_free && i_stat.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### src/ssvs_datapath.sv
// Datapath: digit codes, refresh divider, period register, frame build and output register.
// Depends on ssvs_pkg for widths, character codes and segment/grid lookups.
`default_nettype none

module ssvs_datapath #(
    parameter int NUM_DIGITS = ssvs_pkg::DEF_NUM_DIGITS,
    parameter int FRAME_BITS = ssvs_pkg::DEF_FRAME_BITS,
    parameter int TDATA_W    = ((FRAME_BITS + 7) / 8) * 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ssvs_pkg::PERIOD_W-1:0]     i_cfg_wdata,
    input  wire logic [ssvs_pkg::CHAR_W-1:0]       i_char,
    input  wire ssvs_pkg::t_cmd                    i_cmd,
    output ssvs_pkg::t_stat                        o_stat,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [TDATA_W-1:0]                     o_out_data,   // [FRAME_BITS-1:0] frame
    output logic [ssvs_pkg::INDEX_W-1:0]           o_out_index,
    output logic                                   o_out_last
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DIGITS - 1);

    logic [ssvs_pkg::CODE_W-1:0]   r_dig [NUM_DIGITS];
    logic [ssvs_pkg::PERIOD_W-1:0] r_period;
    logic [ssvs_pkg::PERIOD_W-1:0] r_cd;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_ovalid;
    logic [FRAME_BITS-1:0]         r_frame;
    logic [ssvs_pkg::INDEX_W-1:0]  r_oindex;
    logic                          r_olast;

    logic                          w_is_clear;
    logic                          w_is_num;
    logic                          w_is_space;
    logic [ssvs_pkg::CHAR_W-1:0]   w_char_off;
    logic [ssvs_pkg::CODE_W-1:0]   w_new_code;
    logic [ssvs_pkg::INDEX_W-1:0]  w_idx_ext;
    logic [ssvs_pkg::CODE_W-1:0]   w_cur_code;
    logic [ssvs_pkg::WORD_W-1:0]   w_word;

    // Character decode
    always_comb begin
        w_is_clear = (i_char == ssvs_pkg::CHAR_CLEAR);
        w_is_space = (i_char == ssvs_pkg::CHAR_SPACE);
        w_is_num   = (i_char >= ssvs_pkg::CHAR_ZERO) && (i_char <= ssvs_pkg::CHAR_NINE);
        w_char_off = i_char - ssvs_pkg::CHAR_ZERO;
        w_new_code = w_is_space ? ssvs_pkg::BLANK_CODE : w_char_off[ssvs_pkg::CODE_W-1:0];
    end

    // Digit codes: clear to blank, or shift toward position 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_dig[i] <= (i == NUM_DIGITS - 1) ? '0 : ssvs_pkg::CODE_W'(i & 3);
            end
        end else if (i_cmd.char_we) begin
            if (w_is_clear) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    r_dig[i] <= ssvs_pkg::BLANK_CODE;
                end
            end else if (w_is_num || w_is_space) begin
                for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                    r_dig[i] <= r_dig[i+1];
                end
                r_dig[NUM_DIGITS-1] <= w_new_code;
            end
        end
    end

    // Period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= ssvs_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // Refresh divider; stops at zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd <= ssvs_pkg::CD_RESET;
        end else if (i_cmd.tick && (r_cd != '0)) begin
            r_cd <= (r_cd == ssvs_pkg::PERIOD_W'(1)) ? r_period : r_cd - 1'b1;
        end
    end

    // Scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
        end
    end

    // Frame of the current digit
    always_comb begin
        w_idx_ext  = ssvs_pkg::INDEX_W'(r_idx);
        w_cur_code = r_dig[r_idx];
        w_word     = ssvs_pkg::grid_bit(w_idx_ext)
                   | ssvs_pkg::WORD_W'(ssvs_pkg::seg_bits(w_cur_code));
    end

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_frame  <= w_word[FRAME_BITS-1:0];
            r_oindex <= w_idx_ext;
            r_olast  <= (r_idx == IDX_LAST);
        end
    end

    always_comb begin
        o_stat.cd_one   = (r_cd == ssvs_pkg::PERIOD_W'(1));
        o_stat.idx_last = (r_idx == IDX_LAST);
        o_stat.out_free = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = (TDATA_W)'(r_frame);
    assign o_out_index = r_oindex;
    assign o_out_last  = r_olast;

endmodule

`default_nettype wire

### src/seven_segment_vfd_scanner.sv
// Seven-segment tube scanner: a character or non-scanning tick is accepted while idle.
// A tick that expires the refresh divider starts a scan of NUM_DIGITS frames: the state
// register enters the scan state, then each frame is loaded into the output register, one
// frame per cycle while the sink is ready. Input is held off until the last frame is
// loaded into the single output register.
// Synchronous active-low reset: digits 0,1,2,3,..., final digit 0; divider 1; period 32.
`default_nettype none

module seven_segment_vfd_scanner #(
    parameter int NUM_DIGITS = ssvs_pkg::DEF_NUM_DIGITS,
    parameter int FRAME_BITS = ssvs_pkg::DEF_FRAME_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration: refresh_period
    input  wire logic                                  i_cfg_we,
    input  wire logic [ssvs_pkg::PERIOD_W-1:0]         i_cfg_wdata,
    // Input stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [ssvs_pkg::CHAR_W-1:0]           s_axis_tdata,  // [7:0] char_code
    input  wire logic                                  s_axis_tuser,  // [0] func
    // Output stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [((FRAME_BITS + 7) / 8) * 8-1:0]      m_axis_tdata,  // [FRAME_BITS-1:0] frame
    output logic [ssvs_pkg::INDEX_W-1:0]               m_axis_tuser,  // [3:0] digit_index
    output logic                                       m_axis_tlast
);

    localparam int TDATA_W = ((FRAME_BITS + 7) / 8) * 8;

    ssvs_pkg::t_cmd  w_cmd;
    ssvs_pkg::t_stat w_stat;

    ssvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ssvs_datapath #(
        .NUM_DIGITS (NUM_DIGITS),
        .FRAME_BITS (FRAME_BITS),
        .TDATA_W    (TDATA_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_index (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### tb/tb_seven_segment_vfd_scanner.sv
// Self-checking testbench for seven_segment_vfd_scanner: drives characters and timer
// ticks, predicts every refresh scan frame and checks it. Depends on ssvs_pkg and the RTL.
module tb_seven_segment_vfd_scanner;

    localparam int NDIG       = ssvs_pkg::DEF_NUM_DIGITS;
    localparam int FBITS      = ssvs_pkg::DEF_FRAME_BITS;
    localparam int DATA_W     = ((FBITS + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 4000;

    // Segment pattern per numeral, bits a=0 f=1 b=2 g=3 e=4 c=5 d=6
    localparam logic [ssvs_pkg::SEG_W-1:0] SEG_OF_CODE [10] = '{
        7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h2F
    };
    // Grid bit position of each tube position
    localparam int GRID_POS [NDIG] = '{16, 12, 11, 10, 13, 9, 14, 7, 15};

    typedef struct packed {
        logic [DATA_W-1:0]            frame;
        logic [ssvs_pkg::INDEX_W-1:0] digit;
        logic                         last_flag;
    } t_scan_frame;

    // Digit store and refresh divider shadow, plus the queue of frames still due
    class t_scan_scoreboard;
        logic [ssvs_pkg::CODE_W-1:0]   digits [NDIG];
        logic [ssvs_pkg::PERIOD_W-1:0] countdown;
        logic [ssvs_pkg::PERIOD_W-1:0] period;
        t_scan_frame                   frames_due [$];
        int                            errors;
        int                            scans;

        function new();
            for (int i = 0; i < NDIG; i++) digits[i] = ssvs_pkg::CODE_W'(i % 4);
            digits[NDIG-1] = '0;
            countdown = ssvs_pkg::CD_RESET;
            period    = ssvs_pkg::PERIOD_RESET;
            errors    = 0;
            scans     = 0;
        endfunction

        function void set_period(logic [ssvs_pkg::PERIOD_W-1:0] p);
            period = p;
        endfunction

        function int outstanding();
            return frames_due.size();
        endfunction

        // Apply one accepted input transaction
        function void note_item(logic func, logic [ssvs_pkg::CHAR_W-1:0] ch);
            t_scan_frame f;
            if (func == ssvs_pkg::FUNC_CHAR) begin
                if (ch == ssvs_pkg::CHAR_CLEAR) begin
                    for (int i = 0; i < NDIG; i++) digits[i] = ssvs_pkg::BLANK_CODE;
                end else if ((ch >= ssvs_pkg::CHAR_ZERO && ch <= ssvs_pkg::CHAR_NINE) ||
                             ch == ssvs_pkg::CHAR_SPACE) begin
                    for (int i = 0; i < NDIG - 1; i++) digits[i] = digits[i+1];
                    digits[NDIG-1] = (ch == ssvs_pkg::CHAR_SPACE) ? ssvs_pkg::BLANK_CODE
                                                                  : 4'(ch - ssvs_pkg::CHAR_ZERO);
                end
                return;
            end
            // stopped divider: nothing happens
            if (countdown == 0) return;
            countdown = countdown - 1'b1;
            if (countdown != 0) return;
            countdown = period;
            scans++;
            for (int i = 0; i < NDIG; i++) begin
                f.frame = DATA_W'(1) << GRID_POS[i];
                if (digits[i] <= ssvs_pkg::MAX_NUMERAL)
                    f.frame[ssvs_pkg::SEG_W-1:0] |= SEG_OF_CODE[digits[i]];
                f.digit     = ssvs_pkg::INDEX_W'(i);
                f.last_flag = (i == NDIG - 1);
                frames_due.push_back(f);
            end
        endfunction

        // Compare one accepted output transaction with the oldest frame due
        function void check_result(logic [DATA_W-1:0] data,
                                   logic [ssvs_pkg::INDEX_W-1:0] idx, logic last_flag);
            t_scan_frame f;
            if (frames_due.size() == 0) begin
                $error("unexpected frame: frame %h digit_index %0d last %b", data, idx,
                       last_flag);
                errors++;
                return;
            end
            f = frames_due.pop_front();
            if (data !== f.frame) begin
                $error("frame: expected %h, got %h", f.frame, data);
                errors++;
            end
            if (idx !== f.digit) begin
                $error("digit_index: expected %0d, got %0d", f.digit, idx);
                errors++;
            end
            if (last_flag !== f.last_flag) begin
                $error("last: expected %b, got %b", f.last_flag, last_flag);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [ssvs_pkg::PERIOD_W-1:0]   i_cfg_wdata   = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ssvs_pkg::CHAR_W-1:0]     s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [DATA_W-1:0]               m_axis_tdata;
    logic [ssvs_pkg::INDEX_W-1:0]    m_axis_tuser;
    logic                            m_axis_tlast;

    t_scan_scoreboard sb = new();
    int src_gap_pct    = 25;
    int sink_stall_pct = 25;
    int sink_hold      = 0;
    int idle_cycles    = 0;

    seven_segment_vfd_scanner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Mostly digits and spaces, some clears, some noise bytes
    function automatic logic [ssvs_pkg::CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return ssvs_pkg::CHAR_ZERO + ssvs_pkg::CHAR_W'($urandom_range(0, 9));
        if (r < 78) return ssvs_pkg::CHAR_SPACE;
        if (r < 84) return ssvs_pkg::CHAR_CLEAR;
        return ssvs_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    // Sink readiness with random stalls
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_stall_pct) begin
            sink_hold     <= pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Output check and watchdog on transaction activity
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_seven_segment_vfd_scanner NOT OK");
                $finish;
            end
        end
    end

    // One input transaction, then an optional gap
    task automatic send_item(input logic func, input logic [ssvs_pkg::CHAR_W-1:0] ch);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(func, ch);
        gap = ($urandom_range(0, 99) < src_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let every due frame come out, then write the refresh period
    task automatic drain_and_set_period(input logic [ssvs_pkg::PERIOD_W-1:0] p);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_period(p);
    endtask

    // Random traffic until both the item count and the scan count are reached
    task automatic run_phase(input int n_items, input int tick_pct, input int min_scans);
        int first_scan;
        int count;
        first_scan = sb.scans;
        count      = 0;
        while (count < n_items || sb.scans - first_scan < min_scans) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(ssvs_pkg::FUNC_TICK, ssvs_pkg::CHAR_W'($urandom_range(0, 255)));
            else
                send_item(ssvs_pkg::FUNC_CHAR, pick_char());
            count++;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first tick scans the power-up digits, then edits and ignored bytes
        send_item(ssvs_pkg::FUNC_TICK, 8'h00);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_CLEAR);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_ZERO + 8'd8);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_ZERO);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_SPACE);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_NINE);
        send_item(ssvs_pkg::FUNC_CHAR, 8'h00);
        send_item(ssvs_pkg::FUNC_CHAR, 8'hFF);
        send_item(ssvs_pkg::FUNC_CHAR, 8'h80);
        send_item(ssvs_pkg::FUNC_CHAR, 8'h7F);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_ZERO - 8'd1);   // just below '0'
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_NINE + 8'd1);   // just above '9'
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_SPACE - 8'd1);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_SPACE + 8'd1);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_CLEAR - 8'd1);
        send_item(ssvs_pkg::FUNC_CHAR, ssvs_pkg::CHAR_CLEAR + 8'd1);
        send_item(ssvs_pkg::FUNC_CHAR, 8'h52);              // upper-case R is not a clear
        send_item(ssvs_pkg::FUNC_TICK, 8'hFF);
        send_item(ssvs_pkg::FUNC_TICK, ssvs_pkg::CHAR_CLEAR); // tick payload is ignored
        send_item(ssvs_pkg::FUNC_TICK, 8'hAA);

        // Reset period still in force
        run_phase(40, 45, 1);

        // Fastest refresh, no idling anywhere
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        drain_and_set_period(8'd1);
        run_phase(50, 45, 2);

        src_gap_pct    = 50;
        sink_stall_pct = 10;
        drain_and_set_period(8'd2);
        run_phase(50, 45, 2);

        src_gap_pct    = 5;
        sink_stall_pct = 60;
        drain_and_set_period(8'd7);
        run_phase(50, 50, 2);

        src_gap_pct    = 30;
        sink_stall_pct = 30;
        drain_and_set_period(ssvs_pkg::PERIOD_W'($urandom_range(3, 20)));
        run_phase(60, 50, 2);

        // Slowest refresh, nearly all ticks
        src_gap_pct    = 10;
        sink_stall_pct = 40;
        drain_and_set_period(8'd255);
        run_phase(40, 95, 1);

        // Wind down
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.outstanding() > 0) begin
            $error("%0d frames never arrived", sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_seven_segment_vfd_scanner OK");
        end else begin
            $display("tb_seven_segment_vfd_scanner NOT OK");
        end
        $finish;
    end
endmodule

### files.f
src/ssvs_pkg.sv
src/ssvs_ctrl.sv
src/ssvs_datapath.sv
src/seven_segment_vfd_scanner.sv
tb/tb_seven_segment_vfd_scanner.sv
